// ===== design/rmpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmpu_pkg: shared types and constants for the range maximum store
// Item layouts of both channels, the token control bundle that moves
// between tree-level cells, and default sizes.
// ----------------------------------------------------------------------------
package rmpu_pkg;

    localparam int DEF_ENTRIES    = 1024;
    localparam int DEF_VALUE_BITS = 16;

    localparam int IDX_W = 10;
    localparam int OUT_W = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] index_low;
        logic [IDX_W-1:0] index_high;
        logic [OUT_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] max_value;
        logic             range_error;
    } t_out_item;

    typedef enum logic {
        TOK_WRITE,
        TOK_QUERY
    } t_tok_kind;

    typedef struct packed {
        logic      vld;
        t_tok_kind kind;
    } t_tok_ctl;

endpackage
`default_nettype wire

// ===== design/rmpu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmpu_cell: one level of the maximum tree
// Holds the nodes of its level in a small memory. A write token stores its
// node and reads the sibling to form the parent; a query token reads the
// edge nodes of its half-open range, folds them into the running maximum
// and halves the range for the next level.
// ----------------------------------------------------------------------------
module rmpu_cell #(
    parameter int LEVEL      = 0,
    parameter int LEVELS     = 10,
    parameter int VALUE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rmpu_pkg::t_tok_ctl       i_ctl,
    input  logic [LEVELS:0]          i_lo,
    input  logic [LEVELS:0]          i_hi,
    input  logic [VALUE_BITS-1:0]    i_val,
    output rmpu_pkg::t_tok_ctl       o_ctl,
    output logic [LEVELS:0]          o_lo,
    output logic [LEVELS:0]          o_hi,
    output logic [VALUE_BITS-1:0]    o_val
);
    import rmpu_pkg::*;

    localparam int PW    = LEVELS + 1;
    localparam int IW    = (LEVELS - LEVEL > 0) ? (LEVELS - LEVEL) : 1;
    localparam int DEPTH = 1 << IW;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr_a;
    logic [PW-1:0]         hi_m1;
    logic [VALUE_BITS-1:0] r_rd_a;
    logic [VALUE_BITS-1:0] r_rd_b;

    t_tok_ctl              r_a_ctl;
    logic [PW-1:0]         r_a_lo;
    logic [PW-1:0]         r_a_hi;
    logic [VALUE_BITS-1:0] r_a_val;

    t_tok_ctl              r_o_ctl;
    logic [PW-1:0]         r_o_lo;
    logic [PW-1:0]         r_o_hi;
    logic [VALUE_BITS-1:0] r_o_val;

    logic [PW-1:0]         n_lo;
    logic [PW-1:0]         n_hi;
    logic [VALUE_BITS-1:0] n_val;
    logic                  live;
    logic                  take_l;
    logic                  take_r;

    // a write reads its sibling, a query reads the left edge node
    assign wr_addr   = i_lo[IW-1:0];
    assign rd_addr_a = (i_ctl.kind == TOK_WRITE) ? (wr_addr ^ IW'(1)) : wr_addr;
    assign hi_m1     = i_hi - PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld && i_ctl.kind == TOK_WRITE) begin
            r_mem[wr_addr] <= i_val;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[hi_m1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_a_lo  <= i_lo;
        r_a_hi  <= i_hi;
        r_a_val <= i_val;
        r_o_lo  <= n_lo;
        r_o_hi  <= n_hi;
        r_o_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '{vld: 1'b0, kind: TOK_WRITE};
            r_o_ctl <= '{vld: 1'b0, kind: TOK_WRITE};
        end else begin
            r_a_ctl <= i_ctl;
            r_o_ctl <= r_a_ctl;
        end
    end

    always_comb begin
        live   = r_a_lo < r_a_hi;
        take_l = live && r_a_lo[0];
        take_r = live && r_a_hi[0];
        n_val  = r_a_val;
        n_lo   = r_a_lo >> 1;
        n_hi   = '0;
        case (r_a_ctl.kind)
            TOK_WRITE: begin
                if (r_rd_a > n_val) begin
                    n_val = r_rd_a;
                end
            end
            TOK_QUERY: begin
                if (take_l && r_rd_a > n_val) begin
                    n_val = r_rd_a;
                end
                if (take_r && r_rd_b > n_val) begin
                    n_val = r_rd_b;
                end
                n_lo = (r_a_lo + PW'(take_l)) >> 1;
                n_hi = (r_a_hi - PW'(take_r)) >> 1;
            end
            default: begin
                n_val = r_a_val;
            end
        endcase
    end

    assign o_ctl = r_o_ctl;
    assign o_lo  = r_o_lo;
    assign o_hi  = r_o_hi;
    assign o_val = r_o_val;

endmodule
`default_nettype wire

// ===== design/range_max_point_update_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_max_point_update_core: point-write / range-maximum store
// Segment tree kept as a row of level cells, leaves first. Writes climb the
// row refreshing parents; queries climb it folding edge nodes into a maximum.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------
//  input    | in        | i_valid / o_stall    | i_item (t_in_item)
//  result   | out       | o_valid / i_stall    | o_item (t_out_item)
//
// Writes and in-range queries walk all $clog2(ENTRIES)+1 level cells, each a node
// read, then a merge; a query's result is registered into the output register, and a
// new item is accepted only once the token has left the last cell. One item in the tree.
// Bad queries bypass the cells; writes past the end drop.
// Reset clears control only; the store is undefined until written.
// A result waiting on i_stall sits in the output register plus one spare slot.
// ----------------------------------------------------------------------------
module range_max_point_update_core #(
    parameter int ENTRIES    = rmpu_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = rmpu_pkg::DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rmpu_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output rmpu_pkg::t_out_item o_item
);
    import rmpu_pkg::*;

    localparam int LEVELS = $clog2(ENTRIES);
    localparam int PW     = LEVELS + 1;
    localparam int NCELL  = LEVELS + 1;

    t_tok_ctl              w_ctl [NCELL+1];
    logic [PW-1:0]         w_lo  [NCELL+1];
    logic [PW-1:0]         w_hi  [NCELL+1];
    logic [VALUE_BITS-1:0] w_val [NCELL+1];

    t_tok_ctl              r_tok_ctl;
    logic [PW-1:0]         r_tok_lo;
    logic [PW-1:0]         r_tok_hi;
    logic [VALUE_BITS-1:0] r_tok_val;

    logic                  r_busy;
    logic                  r_pend;
    logic                  r_out_vld;
    t_out_item             r_pend_item;
    t_out_item             r_out_item;

    logic                  acc;
    logic                  is_query;
    logic                  q_err;
    logic                  wr_ok;
    logic                  n_tok_vld;
    logic                  done_q;
    logic                  arr_vld;
    logic                  out_free;
    t_out_item             arr_item;

    assign w_ctl[0] = r_tok_ctl;
    assign w_lo[0]  = r_tok_lo;
    assign w_hi[0]  = r_tok_hi;
    assign w_val[0] = r_tok_val;

    for (genvar k = 0; k < NCELL; k++) begin : g_level
        rmpu_cell #(
            .LEVEL      (k),
            .LEVELS     (LEVELS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_lo    (w_lo[k]),
            .i_hi    (w_hi[k]),
            .i_val   (w_val[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_lo    (w_lo[k+1]),
            .o_hi    (w_hi[k+1]),
            .o_val   (w_val[k+1])
        );
    end

    always_comb begin
        acc       = i_valid && !o_stall;
        is_query  = i_item.mode == MODE_QUERY;
        q_err     = (i_item.index_low > i_item.index_high) ||
                    (int'(i_item.index_high) >= ENTRIES);
        wr_ok     = int'(i_item.index_low) < ENTRIES;
        n_tok_vld = acc && (is_query ? !q_err : wr_ok);
        done_q    = w_ctl[NCELL].vld && w_ctl[NCELL].kind == TOK_QUERY;
        arr_vld   = done_q || (acc && is_query && q_err);
        out_free  = !r_out_vld || !i_stall;
        if (done_q) begin
            arr_item = '{max_value: OUT_W'(w_val[NCELL]), range_error: 1'b0};
        end else begin
            arr_item = '{max_value: '0, range_error: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_ctl <= '{vld: 1'b0, kind: TOK_WRITE};
            r_busy    <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_tok_ctl <= '{vld: n_tok_vld, kind: is_query ? TOK_QUERY : TOK_WRITE};
            if (n_tok_vld) begin
                r_busy <= 1'b1;
            end else if (w_ctl[NCELL].vld) begin
                r_busy <= 1'b0;
            end
            // spare slot drains first; a new result only lands when it is empty
            if (r_pend) begin
                if (out_free) begin
                    r_pend    <= 1'b0;
                    r_out_vld <= 1'b1;
                end
            end else if (arr_vld) begin
                if (out_free) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_pend <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_lo  <= PW'(i_item.index_low);
        r_tok_hi  <= is_query ? (PW'(i_item.index_high) + PW'(1)) : '0;
        r_tok_val <= is_query ? '0 : VALUE_BITS'(i_item.value);
        if (r_pend) begin
            if (out_free) begin
                r_out_item <= r_pend_item;
            end
        end else if (arr_vld) begin
            if (out_free) begin
                r_out_item <= arr_item;
            end else begin
                r_pend_item <= arr_item;
            end
        end
    end

    assign o_stall = r_busy || r_pend;
    assign o_valid = r_out_vld;
    assign o_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_end_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[NCELL].vld |-> r_busy)
        else $error("token left the tree with no item in flight");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_ctl.vld |-> r_busy)
        else $error("launched token not tracked as busy");

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_vld)
        else $error("spare result held while output register empty");

    a_busy_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_pend))
        else $error("item in flight while a result is still parked");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_max_point_update_core
// Drives point writes and range-maximum queries, including empty ranges,
// through the valid/stall input channel. A mirror of the value array in the
// bench predicts each query answer. Every result taken from the output
// channel is compared field by field with the oldest pending answer.
// Queries only cover entries that have already been written. Both sides
// idle and stall at random, with some stretches that run at full rate.
// ----------------------------------------------------------------------------
module tb;
    import rmpu_pkg::*;

    localparam int ENTRIES      = DEF_ENTRIES;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 8;
    localparam logic [OUT_W-1:0] VALUE_MASK = OUT_W'((64'd1 << DEF_VALUE_BITS) - 1);

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    // bench copy of the array and of the answers still owed
    bit [OUT_W-1:0] value_mirror [ENTRIES];
    bit             was_written  [ENTRIES];
    int             written_list [$];
    t_out_item      pending_max_q[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int stall_left     = 0;
    int in_gap_max     = MAX_GAP;
    int out_gap_max    = MAX_GAP;

    range_max_point_update_core #(
        .ENTRIES   (ENTRIES),
        .VALUE_BITS(DEF_VALUE_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(input logic mode, input int lo, input int hi,
                                           input logic [OUT_W-1:0] val);
        t_in_item it;
        it.mode       = mode;
        it.index_low  = IDX_W'(lo);
        it.index_high = IDX_W'(hi);
        it.value      = val;
        return it;
    endfunction

    function automatic t_out_item fold_range_max(input t_in_item it);
        t_out_item      ans;
        bit [OUT_W-1:0] best;
        ans  = '0;
        best = '0;
        if (it.index_low > it.index_high || int'(it.index_high) >= ENTRIES) begin
            ans.range_error = 1'b1;
        end else begin
            for (int k = int'(it.index_low); k <= int'(it.index_high); k++) begin
                if (value_mirror[k] > best) begin
                    best = value_mirror[k];
                end
            end
            ans.max_value = best;
        end
        return ans;
    endfunction

    task automatic record_item(input t_in_item it);
        int idx;
        idx = int'(it.index_low);
        if (it.mode == MODE_WRITE) begin
            if (idx < ENTRIES) begin
                value_mirror[idx] = it.value & VALUE_MASK;
                if (!was_written[idx]) begin
                    was_written[idx] = 1'b1;
                    written_list.push_back(idx);
                end
            end
        end else begin
            pending_max_q.push_back(fold_range_max(it));
        end
    endtask

    // hold valid across back-to-back items; drop it only for a drawn gap
    task automatic send_item(input t_in_item it);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item  = it;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        record_item(it);
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected max_value=%h range_error=%b, got max_value=%h range_error=%b",
                     $time, what, want.max_value, want.range_error,
                     got.max_value, got.range_error);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = $urandom_range(0, out_gap_max);
            if (pending_max_q.size() == 0) begin
                note_mismatch("result with no query pending", '0, o_item);
            end else begin
                want = pending_max_q.pop_front();
                if (o_item.max_value !== want.max_value
                        || o_item.range_error !== want.range_error) begin
                    note_mismatch("query result", want, o_item);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("range_max_point_update_core: mismatch");
                $finish;
            end
        end
    end

    // extremes of index and value
    task automatic test_boundary_writes();
        send_item(make_item(MODE_WRITE, 0, ENTRIES - 1, 16'hFFFF));
        send_item(make_item(MODE_WRITE, 1, 0, 16'h0000));
        send_item(make_item(MODE_WRITE, 2, 512, 16'h5555));
        send_item(make_item(MODE_WRITE, 511, 3, 16'h7FFF));
        send_item(make_item(MODE_WRITE, 512, ENTRIES - 1, 16'hAAAA));
        send_item(make_item(MODE_WRITE, ENTRIES - 2, 0, 16'h8000));
        send_item(make_item(MODE_WRITE, ENTRIES - 1, 341, 16'h0001));
    endtask

    task automatic test_point_and_span_queries();
        send_item(make_item(MODE_QUERY, 0, 0, 16'hFFFF));
        send_item(make_item(MODE_QUERY, 1, 1, 16'h0000));
        send_item(make_item(MODE_QUERY, 0, 2, 16'h1234));
        send_item(make_item(MODE_QUERY, ENTRIES - 1, ENTRIES - 1, 16'hFFFF));
        send_item(make_item(MODE_QUERY, ENTRIES - 2, ENTRIES - 1, 16'h0000));
        send_item(make_item(MODE_QUERY, 511, 512, 16'hFFFF));
        // the old maximum at index 0 must vanish from the span
        send_item(make_item(MODE_WRITE, 0, 0, 16'h0000));
        send_item(make_item(MODE_QUERY, 0, 2, 16'h0000));
        send_item(make_item(MODE_QUERY, 1, 2, 16'hFFFF));
    endtask

    task automatic test_empty_ranges();
        send_item(make_item(MODE_QUERY, 1, 0, 16'hFFFF));
        send_item(make_item(MODE_QUERY, ENTRIES - 1, 0, 16'h0000));
        send_item(make_item(MODE_QUERY, ENTRIES - 1, ENTRIES - 2, 16'hFFFF));
        send_item(make_item(MODE_QUERY, 512, 511, 16'h0000));
    endtask

    // writes, half of them near written entries, queries inside written runs, some empty ranges
    task automatic test_random_traffic();
        t_in_item       it;
        int             pick;
        int             lo;
        int             hi;
        int             run;
        logic [OUT_W-1:0] val;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 100) % 4)
                0: begin in_gap_max = MAX_GAP; out_gap_max = MAX_GAP; end
                1: begin in_gap_max = 0;       out_gap_max = MAX_GAP; end
                2: begin in_gap_max = MAX_GAP; out_gap_max = 0;       end
                default: begin in_gap_max = 0; out_gap_max = 0;       end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 40 || written_list.size() == 0) begin
                if ($urandom_range(0, 1) == 0 || written_list.size() == 0) begin
                    lo = $urandom_range(0, ENTRIES - 1);
                end else begin
                    lo = written_list[$urandom_range(0, written_list.size() - 1)]
                         + $urandom_range(0, 8) - 4;
                    if (lo < 0) lo = 0;
                    if (lo > ENTRIES - 1) lo = ENTRIES - 1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    val = ($urandom_range(0, 1) == 0) ? '0 : '1;
                end else begin
                    val = OUT_W'($urandom);
                end
                it = make_item(MODE_WRITE, lo, $urandom_range(0, ENTRIES - 1), val);
            end else if (pick < 90) begin
                lo  = written_list[$urandom_range(0, written_list.size() - 1)];
                run = 1;
                while (lo + run < ENTRIES && was_written[lo + run]) run++;
                hi = lo + $urandom_range(0, run - 1);
                it = make_item(MODE_QUERY, lo, hi, OUT_W'($urandom));
            end else begin
                hi = $urandom_range(0, ENTRIES - 2);
                lo = $urandom_range(hi + 1, ENTRIES - 1);
                it = make_item(MODE_QUERY, lo, hi, OUT_W'($urandom));
            end
            send_item(it);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_boundary_writes();
        test_point_and_span_queries();
        test_empty_ranges();
        test_random_traffic();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_max_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("range_max_point_update_core: match");
        end else begin
            $display("range_max_point_update_core: mismatch");
        end
        $finish;
    end

endmodule
